// ===== rtl/amplitude_histogram_peak_top_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef AMPLITUDE_HISTOGRAM_PEAK_TOP_MACROS_SVH
`define AMPLITUDE_HISTOGRAM_PEAK_TOP_MACROS_SVH

// Overlapping implication: the consequent must hold in the same cycle.
`define AHP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent must hold in the following cycle.
`define AHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent, also while reset is low.
`define AHP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ahp_pkg.sv =====
package ahp_pkg;

    localparam int NUM_BINS = 16;
    localparam int BIN_W    = 4;
    localparam int CNT_W    = 32;
    localparam int PEAK_W   = 16;
    localparam int GAIN_W   = 24;
    localparam int DIV_STEPS = GAIN_W;
    localparam int STEP_W   = 5;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // 32768 in Q8.
    localparam logic [GAIN_W-1:0] FULL_SCALE_Q8 = 24'd8388608;
    localparam logic [GAIN_W-1:0] UNITY_Q8      = 24'd256;
    localparam logic [CNT_W-1:0]  CNT_MAX       = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMP_READ,
        ST_SMP_WRITE,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/amplitude_histogram_peak_top.sv =====
// Per-channel amplitude histogram with a shared peak meter. Each input word carries an
// opcode in s_tuser: a sample word adds one to its channel's sample count and to one of
// 16 amplitude bins (bin = (sample >> 12) + 8, so bin 0 holds the most negative values),
// and raises the peak register to the sample's magnitude if that is larger; samples on
// channels at or above CHANNELS are dropped. A read word returns one result word with
// the requested bin count, the channel's sample count (both zero for an unused channel),
// the peak, and the headroom gain floor(8388608 / peak) in Q8, never below 256 and 256
// when the peak is zero. A clear word zeroes every counter and the peak; opcode 3 is
// ignored. All counters saturate at 2^32-1. The block handles one word at a time and
// holds s_tready low while busy: a sample is accepted, read from the single-port bin
// counter memory and written back incremented; a read is accepted, runs the bit-serial
// restoring divider that forms the gain one quotient bit at a time and then loads the
// output register, waiting while that register stays full; a clear or ignored word is
// done when it is accepted. The bin memory needs no clearing pass after reset: each
// entry has a valid bit that reset and clear drop at once.
module amplitude_histogram_peak_top
    import ahp_pkg::*;
#(
    parameter int CHANNELS = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0 up: channel[2:0], sample[18:3], bin[22:19], zero fill.
    input  logic [23:0]  s_tdata,
    // Fields from bit 0 up: opcode[1:0].
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0 up: bin_count[31:0], channel_samples[63:32], peak[79:64],
    // gain_q8[103:80].
    output logic [103:0] m_tdata
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH  = CHANNELS * NUM_BINS;
    localparam int ADDR_W = CH_W + BIN_W;
    localparam logic [3:0] CHANNELS_4 = 4'(CHANNELS);

    // Unpacked input fields.
    logic [1:0]        in_op;
    logic [2:0]        in_channel;
    logic [15:0]       in_sample;
    logic [BIN_W-1:0]  in_bin;
    logic              in_fire;
    logic              in_ch_ok;
    logic [16:0]       in_neg;
    logic [PEAK_W-1:0] in_mag;
    logic [BIN_W-1:0]  in_sample_bin;

    assign in_op         = s_tuser;
    assign in_channel    = s_tdata[2:0];
    assign in_sample     = s_tdata[18:3];
    assign in_bin        = s_tdata[22:19];
    assign in_fire       = s_tvalid & s_tready;
    assign in_ch_ok      = ({1'b0, in_channel} < CHANNELS_4);
    assign in_neg        = 17'h10000 - {1'b0, in_sample};
    // The magnitude of -32768 is 32768, which still fits in 16 unsigned bits.
    assign in_mag        = in_sample[15] ? in_neg[15:0] : in_sample;
    assign in_sample_bin = {~in_sample[15], in_sample[14:12]};

    state_t state_reg, state_next;

    // Item context held while the sequencer works on it.
    logic [ADDR_W-1:0] addr_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              ch_ok_reg;
    logic [PEAK_W-1:0] mag_reg;

    // Counters and peak.
    logic [CNT_W-1:0]  bin_mem [DEPTH];
    logic [CNT_W-1:0]  rd_data_reg;
    logic [DEPTH-1:0]  bin_valid_reg;
    logic [CNT_W-1:0]  smp_cnt_reg [CHANNELS];
    logic [PEAK_W-1:0] peak_reg;

    // Shared divider unit.
    logic [PEAK_W-1:0] rem_reg;
    logic [GAIN_W-1:0] quo_reg;
    logic [GAIN_W-1:0] dvd_reg;
    logic [STEP_W-1:0] step_reg;
    logic [16:0]       div_trial;
    logic              div_ge;
    logic [16:0]       div_diff;

    // Sequencer outputs.
    logic mem_we;
    logic div_run;
    logic out_load;

    logic [CNT_W-1:0]  bin_old;
    logic [CNT_W-1:0]  bin_count;
    logic [CNT_W-1:0]  chan_count;
    logic [GAIN_W-1:0] gain_q8;

    logic              m_tvalid_reg;
    logic [103:0]      m_tdata_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_op == OP_SAMPLE && in_ch_ok) begin
                        state_next = ST_SMP_READ;
                    end else if (in_op == OP_READ) begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_SMP_READ:  state_next = ST_SMP_WRITE;
            ST_SMP_WRITE: state_next = ST_IDLE;
            ST_DIV: begin
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready = 1'b0;
        mem_we   = 1'b0;
        div_run  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:      s_tready = 1'b1;
            ST_SMP_READ:  ;
            ST_SMP_WRITE: mem_we = 1'b1;
            ST_DIV:       div_run = 1'b1;
            ST_OUT:       out_load = !m_tvalid_reg || m_tready;
            default:      ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            addr_reg  <= {in_channel[CH_W-1:0],
                          (in_op == OP_SAMPLE) ? in_sample_bin : in_bin};
            ch_reg    <= in_channel[CH_W-1:0];
            ch_ok_reg <= in_ch_ok;
            mag_reg   <= in_mag;
        end
    end

    // Bin counter memory: one address, read every cycle, written on sample write back.
    assign bin_old = bin_valid_reg[addr_reg] ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bin_mem[addr_reg] <= sat_inc(bin_old);
        end
        rd_data_reg <= bin_mem[addr_reg];
    end

    // Valid bits, sample counters and peak are cleared by reset and by a clear word.
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && in_op == OP_CLEAR)) begin
            bin_valid_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                smp_cnt_reg[i] <= '0;
            end
            peak_reg <= '0;
        end else if (mem_we) begin
            bin_valid_reg[addr_reg] <= 1'b1;
            smp_cnt_reg[ch_reg]     <= sat_inc(smp_cnt_reg[ch_reg]);
            if (mag_reg > peak_reg) begin
                peak_reg <= mag_reg;
            end
        end
    end

    // Restoring division of 2^23 by the peak, one quotient bit per cycle.
    assign div_trial = {rem_reg, dvd_reg[GAIN_W-1]};
    assign div_diff  = div_trial - {1'b0, peak_reg};
    assign div_ge    = (div_trial >= {1'b0, peak_reg});

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvd_reg  <= FULL_SCALE_Q8;
            step_reg <= '0;
        end else if (div_run) begin
            rem_reg  <= div_ge ? div_diff[PEAK_W-1:0] : div_trial[PEAK_W-1:0];
            quo_reg  <= {quo_reg[GAIN_W-2:0], div_ge};
            dvd_reg  <= {dvd_reg[GAIN_W-2:0], 1'b0};
            step_reg <= step_reg + 1'b1;
        end
    end

    // Result assembly; an unused channel reads as zero counts.
    assign bin_count  = ch_ok_reg ? bin_old : '0;
    assign chan_count = ch_ok_reg ? smp_cnt_reg[ch_reg] : '0;

    always_comb begin
        if (peak_reg == '0 || quo_reg < UNITY_Q8) begin
            gain_q8 = UNITY_Q8;
        end else begin
            gain_q8 = quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {gain_q8, peak_reg, chan_count, bin_count};
        end
    end

endmodule

// ===== rtl/ahp_checker.sv =====
`include "amplitude_histogram_peak_top_macros.svh"

module ahp_checker
    import ahp_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [23:0]  s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    logic in_fire;
    logic busy_op;

    assign in_fire = s_tvalid && s_tready;
    assign busy_op = (s_tuser == OP_SAMPLE) || (s_tuser == OP_READ);

    // No result may appear straight out of reset.
    `AHP_ASSERT_NEXT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // A result that is not taken must hold.
    `AHP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // A read on channel 0 leaves the block busy for the divider; so does a sample on channel 0.
    `AHP_ASSERT_NEXT(a_busy_after_work, aclk, aresetn, in_fire && busy_op && s_tdata[2:0] == 3'd0, !s_tready, "ready right after sample or read")

    // The gain is 32768/peak in Q8, clamped at unity, and unity for a zero peak.
    `AHP_ASSERT_SAME(a_gain_range, aclk, aresetn, m_tvalid, m_tdata[103:80] >= UNITY_Q8 && m_tdata[103:80] <= FULL_SCALE_Q8 && (m_tdata[79:64] != 16'd0 || m_tdata[103:80] == UNITY_Q8) && m_tdata[79:64] <= 16'h8000, "gain or peak out of range")

endmodule

bind amplitude_histogram_peak_top ahp_checker u_ahp_checker (.*);
